// ===== hw/rtl/fqsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_pkg
// Request codes, status codes and controller state type of the search queue.
// ----------------------------------------------------------------------------
package fqsr_pkg;

   localparam logic [2:0] REQ_ENQUEUE  = 3'd0;
   localparam logic [2:0] REQ_DEQUEUE  = 3'd1;
   localparam logic [2:0] REQ_CONTAINS = 3'd2;
   localparam logic [2:0] REQ_REVERSE  = 3'd3;
   localparam logic [2:0] REQ_CLEAR    = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FIX    = 3'b010,
      ST_SEARCH = 3'b100
   } state_type;

endpackage

// ===== hw/rtl/fifo_queue_with_search_reverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse
// Bounded ring queue with enqueue, dequeue, contains search, reverse and
// clear; one result word per request word.
//
// channel   ports                        handshake
// request   req_type, req_data_value     taken when start is high, busy low
// response  rsp_*                        one cycle, marked by rsp_strobe
//
// Enqueue, reverse, clear, unused codes, a search of an empty queue and
// dequeue that empties or fails answer in the cycle after acceptance; busy
// stays low, so a word per cycle.
// Dequeue that leaves one or more entries answers from ST_FIX: the new front
// is fetched from the entry RAM read port, with busy high for one cycle.
// A contains search walks the entries through the RAM read port, one per
// cycle, with busy high until a match or the last entry has been compared.
// Reset is synchronous; the entry RAM needs no clearing pass. The receiver
// cannot stall the response.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_reverse
   import fqsr_pkg::*;
#(
   parameter  int DEPTH      = 16,
   parameter  int DATA_WIDTH = 32,
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_type,
   input  logic [DATA_WIDTH-1:0] req_data_value,
   output logic                  rsp_strobe,
   output logic [DATA_WIDTH-1:0] rsp_data_out,
   output logic [DATA_WIDTH-1:0] rsp_front_value,
   output logic [DATA_WIDTH-1:0] rsp_back_value,
   output logic [CNT_W-1:0]      rsp_length,
   output logic                  rsp_is_empty,
   output logic                  rsp_found,
   output logic [1:0]            rsp_status
);

   localparam logic [PTR_W:0]   DEPTH_R = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      front_ptr_ff, front_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  strobe_ff, strobe_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] data_out_ff, data_out_in;
   logic                  found_ff, found_in;
   logic [1:0]            status_ff, status_in;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [CNT_W-1:0]      count_m1;
   logic [PTR_W-1:0]      slot_tail;
   logic [PTR_W-1:0]      slot_next;
   logic [PTR_W-1:0]      slot_last;
   logic [PTR_W-1:0]      slot_idx;
   logic                  issue;

   function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off,
                                                   input logic             rev);
      logic [PTR_W:0] sum;
      if (!rev) begin
         sum = {1'b0, base} + {1'b0, off};
         if (sum >= DEPTH_R) begin
            sum = sum - DEPTH_R;
         end
      end else if (base >= off) begin
         sum = {1'b0, base} - {1'b0, off};
      end else begin
         sum = {1'b0, base} + DEPTH_R - {1'b0, off};
      end
      return sum[PTR_W-1:0];
   endfunction

   assign count_m1  = count_ff - 1'b1;
   assign slot_tail = ring_slot(front_ptr_ff, count_ff[PTR_W-1:0], rev_ff);
   assign slot_next = ring_slot(front_ptr_ff, PTR_W'(1), rev_ff);
   assign slot_last = ring_slot(front_ptr_ff, count_m1[PTR_W-1:0], rev_ff);
   assign slot_idx  = ring_slot(front_ptr_ff, idx_ff[PTR_W-1:0], rev_ff);
   assign issue     = (idx_ff != count_ff);

   assign wr_addr = slot_tail;
   assign rd_addr = (state_ff == ST_SEARCH) ? slot_idx : slot_next;

   fqsr_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH),
      .ADDR_W(PTR_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_data_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      front_ptr_in = front_ptr_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      idx_in       = idx_ff;
      rd_valid_in  = rd_valid_ff;
      strobe_in    = 1'b0;
      front_in     = front_ff;
      back_in      = back_ff;
      key_in       = key_ff;
      data_out_in  = data_out_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in   = 1'b1;
               data_out_in = '0;
               found_in    = 1'b0;
               status_in   = STATUS_OK;
               case (req_type)
                  REQ_ENQUEUE: begin
                     if (count_ff >= DEPTH_C) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        back_in  = req_data_value;
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           front_in = req_data_value;
                        end
                     end
                  end
                  REQ_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        data_out_in  = front_ff;
                        front_ptr_in = slot_next;
                        count_in     = count_m1;
                        if (count_ff > CNT_W'(1)) begin
                           state_in  = ST_FIX;
                           strobe_in = 1'b0;
                        end
                     end
                  end
                  REQ_CONTAINS: begin
                     if (count_ff != '0) begin
                        state_in    = ST_SEARCH;
                        strobe_in   = 1'b0;
                        idx_in      = '0;
                        rd_valid_in = 1'b0;
                        key_in      = req_data_value;
                     end
                  end
                  REQ_REVERSE: begin
                     rev_in = !rev_ff;
                     if (count_ff != '0) begin
                        front_ptr_in = slot_last;
                        front_in     = back_ff;
                        back_in      = front_ff;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in     = '0;
                     front_ptr_in = '0;
                     rev_in       = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIX: begin
            front_in  = rd_data;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SEARCH: begin
            if (rd_valid_ff && (rd_data == key_ff)) begin
               found_in    = 1'b1;
               strobe_in   = 1'b1;
               rd_valid_in = 1'b0;
               state_in    = ST_IDLE;
            end else if (!issue && !rd_valid_ff) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_valid_in = issue;
               if (issue) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ptr_ff <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ptr_ff <= front_ptr_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff    <= front_in;
      back_ff     <= back_in;
      key_ff      <= key_in;
      data_out_ff <= data_out_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_data_out    = data_out_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_front_value = rsp_is_empty ? '0 : front_ff;
   assign rsp_back_value  = rsp_is_empty ? '0 : back_ff;
   assign rsp_length      = count_ff;
   assign rsp_found       = found_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== hw/rtl/fqsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fqsr_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fqsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_checker
// Port-level checks of the search queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqsr_checker
   import fqsr_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [2:0]            req_type,
   input logic                  rsp_strobe,
   input logic [DATA_WIDTH-1:0] rsp_front_value,
   input logic [DATA_WIDTH-1:0] rsp_back_value,
   input logic [CNT_W-1:0]      rsp_length,
   input logic                  rsp_is_empty
);

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_ENQUEUE || req_type == REQ_REVERSE ||
                          req_type == REQ_CLEAR)) |=> (rsp_strobe && !busy))
      else $error("single-cycle request did not answer next cycle");

   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_CLEAR) |=> (rsp_length == '0))
      else $error("clear left entries");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_length == '0)))
      else $error("empty flag disagrees with length");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_empty) |-> (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty queue shows nonzero front or back");

endmodule

bind fifo_queue_with_search_reverse fqsr_checker #(
   .DEPTH     (DEPTH),
   .DATA_WIDTH(DATA_WIDTH)
) u_fqsr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_type       (req_type),
   .rsp_strobe     (rsp_strobe),
   .rsp_front_value(rsp_front_value),
   .rsp_back_value (rsp_back_value),
   .rsp_length     (rsp_length),
   .rsp_is_empty   (rsp_is_empty)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring queue with search and reverse. A shadow
// copy of the queue predicts every response word when its request is taken;
// a monitor compares each strobed response, field by field, with the oldest
// prediction. Stimulus is a directed opening followed by fill, drain and
// mixed bursts, with random gaps between request words.
// ----------------------------------------------------------------------------
module tb_top
   import fqsr_pkg::*;
();

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int RANDOM_WORDS = 1900;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] removed;
      logic [31:0] front;
      logic [31:0] back;
      logic [4:0]  len;
      logic        empty;
      logic        found;
      logic [1:0]  status;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_type = REQ_ENQUEUE;
   logic [31:0] req_data_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_data_out;
   logic [31:0] rsp_front_value;
   logic [31:0] rsp_back_value;
   logic [4:0]  rsp_length;
   logic        rsp_is_empty;
   logic        rsp_found;
   logic [1:0]  rsp_status;

   fifo_queue_with_search_reverse #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_data_value(req_data_value),
      .rsp_strobe(rsp_strobe),
      .rsp_data_out(rsp_data_out),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value),
      .rsp_length(rsp_length),
      .rsp_is_empty(rsp_is_empty),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // shadow queue
   logic [31:0] shadow_mem [DEPTH];
   logic [3:0]  shadow_front = '0;
   logic [4:0]  shadow_count = '0;
   logic        shadow_rev = 1'b0;

   req_word_type req_word_q[$];
   rsp_word_type snapshot_q[$];

   int bad_words = 0;
   int checked_words = 0;
   int kind_seen [8];
   int full_refusals = 0;
   int empty_dequeues = 0;
   int search_hits = 0;
   int peak_len = 0;

   function automatic logic [3:0] slot_at(logic [4:0] idx);
      return shadow_rev ? shadow_front - idx[3:0] : shadow_front + idx[3:0];
   endfunction

   function automatic rsp_word_type snapshot_after(req_word_type w);
      rsp_word_type r;
      int i;
      r = '0;
      case (w.kind)
         REQ_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_mem[slot_at(shadow_count)] = w.value;
               shadow_count = shadow_count + 5'd1;
            end
         end
         REQ_DEQUEUE: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.removed = shadow_mem[shadow_front];
               shadow_front = slot_at(5'd1);
               shadow_count = shadow_count - 5'd1;
            end
         end
         REQ_CONTAINS: begin
            for (i = 0; i < shadow_count; i++)
               if (shadow_mem[slot_at(5'(i))] == w.value) r.found = 1'b1;
         end
         REQ_REVERSE: begin
            if (shadow_count != 0) shadow_front = slot_at(shadow_count - 5'd1);
            shadow_rev = ~shadow_rev;
         end
         REQ_CLEAR: begin
            shadow_count = '0;
            shadow_front = '0;
            shadow_rev = 1'b0;
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         r.front = shadow_mem[shadow_front];
         r.back  = shadow_mem[slot_at(shadow_count - 5'd1)];
      end
      r.len   = shadow_count;
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [2:0] pick_kind(mix_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MIX_FILL: begin
            if (r < 72) return REQ_ENQUEUE;
            if (r < 80) return REQ_DEQUEUE;
            if (r < 92) return REQ_CONTAINS;
            if (r < 97) return REQ_REVERSE;
         end
         MIX_DRAIN: begin
            if (r < 15) return REQ_ENQUEUE;
            if (r < 78) return REQ_DEQUEUE;
            if (r < 88) return REQ_CONTAINS;
            if (r < 95) return REQ_REVERSE;
            if (r < 97) return REQ_CLEAR;
         end
         default: begin
            if (r < 36) return REQ_ENQUEUE;
            if (r < 66) return REQ_DEQUEUE;
            if (r < 84) return REQ_CONTAINS;
            if (r < 92) return REQ_REVERSE;
            if (r < 96) return REQ_CLEAR;
         end
      endcase
      return 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
   endfunction

   task automatic queue_word(logic [2:0] kind, logic [31:0] value);
      req_word_type w;
      w.kind = kind;
      w.value = value;
      req_word_q.push_back(w);
   endtask

   // driver
   req_word_type cur_req;
   req_word_type next_req;
   rsp_word_type snap;
   int  gap_left = 0;
   int  accepted = 0;
   bit  steady = 1'b0;
   bit  slot_free;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         slot_free = !start;
         if (start && !busy) begin
            cur_req.kind = req_type;
            cur_req.value = req_data_value;
            snap = snapshot_after(cur_req);
            snapshot_q.push_back(snap);
            kind_seen[cur_req.kind]++;
            if (snap.status == STATUS_FULL) full_refusals++;
            if (snap.status == STATUS_EMPTY) empty_dequeues++;
            if (snap.found) search_hits++;
            if (int'(snap.len) > peak_len) peak_len = int'(snap.len);
            accepted++;
            if (accepted % 150 == 0) steady = ($urandom_range(0, 3) == 0);
            gap_left = steady ? 0 : pick_gap();
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_word_q.size() > 0) begin
               next_req = req_word_q.pop_front();
               req_type <= next_req.kind;
               req_data_value <= next_req.value;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   rsp_word_type seen;
   rsp_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen = {rsp_data_out, rsp_front_value, rsp_back_value, rsp_length,
                 rsp_is_empty, rsp_found, rsp_status};
         if (snapshot_q.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("%0t: response word with none pending: out=%h front=%h back=%h",
                        $time, seen.removed, seen.front, seen.back);
         end else begin
            want = snapshot_q.pop_front();
            checked_words++;
            if (seen !== want) begin
               bad_words++;
               if (bad_words <= 10) begin
                  $write("%0t: mismatch exp out=%h front=%h back=%h",
                         $time, want.removed, want.front, want.back);
                  $display(" len=%0d empty=%b found=%b st=%0d",
                           want.len, want.empty, want.found, want.status);
                  $write("%0t:          got out=%h front=%h back=%h",
                         $time, seen.removed, seen.front, seen.back);
                  $display(" len=%0d empty=%b found=%b st=%0d",
                           seen.len, seen.empty, seen.found, seen.status);
               end
            end
         end
      end
   end

   initial begin
      int made;
      int seg;
      int j;
      int k;
      int r;
      mix_type mode;
      logic [2:0]  kind;
      logic [31:0] value;
      logic [31:0] pool [8];

      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;

      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_REVERSE, 32'h0);
      queue_word(REQ_CONTAINS, 32'h0);
      queue_word(3'd5, 32'hFFFF_FFFF);
      queue_word(3'd6, 32'h0);
      queue_word(REQ_UNUSED_HI, 32'hFFFF_FFFF);
      queue_word(REQ_ENQUEUE, 32'h0);
      queue_word(REQ_ENQUEUE, 32'hFFFF_FFFF);
      queue_word(REQ_ENQUEUE, 32'h5A5A_5A5A);
      queue_word(REQ_CONTAINS, 32'hFFFF_FFFF);
      queue_word(REQ_CONTAINS, 32'h1234_5678);
      queue_word(REQ_REVERSE, 32'h0);
      queue_word(REQ_CONTAINS, 32'h0);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_ENQUEUE, 32'h8000_0001);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_REVERSE, 32'h0);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_ENQUEUE, 32'h0000_0001);
      queue_word(REQ_CLEAR, 32'h0);
      queue_word(REQ_DEQUEUE, 32'h0);
      queue_word(REQ_ENQUEUE, 32'h7FFF_FFFE);

      made = 0;
      while (made < RANDOM_WORDS) begin
         case ($urandom_range(0, 2))
            0: mode = MIX_FILL;
            1: mode = MIX_DRAIN;
            default: mode = MIX_MIXED;
         endcase
         seg = $urandom_range(10, 60);
         for (k = 0; k < 8; k++) begin
            r = $urandom_range(0, 9);
            pool[k] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         end
         for (j = 0; j < seg; j++) begin
            kind = pick_kind(mode);
            r = $urandom_range(0, 99);
            value = $urandom;
            if (kind == REQ_CONTAINS && r < 70) value = pool[$urandom_range(0, 7)];
            if (kind == REQ_ENQUEUE && r < 60) value = pool[$urandom_range(0, 7)];
            queue_word(kind, value);
            made++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // hold until every word is taken and answered
      do @(posedge clock);
      while (req_word_q.size() != 0 || start || snapshot_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (snapshot_q.size() != 0) bad_words += snapshot_q.size();

      $write("Run took %0d request words and checked %0d responses:",
             accepted, checked_words);
      $display(" enqueue %0d, dequeue %0d, search %0d, reverse %0d, clear %0d.",
               kind_seen[REQ_ENQUEUE], kind_seen[REQ_DEQUEUE],
               kind_seen[REQ_CONTAINS], kind_seen[REQ_REVERSE], kind_seen[REQ_CLEAR]);
      $display("Refused enqueues %0d, dequeues on empty %0d, search hits %0d, peak length %0d.",
               full_refusals, empty_dequeues, search_hits, peak_len);
      if (bad_words == 0) begin
         $display("PASS fifo_queue_with_search_reverse");
      end else begin
         $display("FAIL fifo_queue_with_search_reverse");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL fifo_queue_with_search_reverse");
      $finish;
   end

endmodule

// ===== fifo_queue_with_search_reverse.f =====
hw/rtl/fqsr_pkg.sv
hw/rtl/fqsr_ram.sv
hw/rtl/fifo_queue_with_search_reverse.sv
hw/rtl/fqsr_checker.sv
test/tb_top.sv
